// ----- rtl/core/inode_free_list_allocator_top_assert.svh -----
// Assertion macros for the inode allocator checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef INODE_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define INODE_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define IFLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IFLA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ifla_pkg.sv -----
// ----------------------------------------------------------------------------
// ifla_pkg
// Shared types and codes of the inode free list allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ifla_pkg;

  localparam int NUM_W  = 10;  // inode number field
  localparam int CNT_W  = 11;  // free count field
  localparam int STAT_W = 2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    C_INIT,
    C_IDLE,
    C_EXEC,
    C_REFILL,
    C_POP
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RF_IDLE,
    RF_SCAN,
    RF_COPY
  } refill_state_e;

endpackage

`default_nettype wire

// ----- rtl/core/ifla_if.sv -----
// ----------------------------------------------------------------------------
// ifla_if
// Request and response channels of the inode allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ifla_req_if;
  import ifla_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [NUM_W-1:0] inode_number;

  modport source (output valid, output func, output inode_number, input ready);
  modport sink   (input valid, input func, input inode_number, output ready);
endinterface

interface ifla_rsp_if;
  import ifla_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [NUM_W-1:0]  granted_inode;
  logic [CNT_W-1:0]  free_count;

  modport source (output valid, output status, output granted_inode, output free_count,
                  input ready);
  modport sink   (input valid, input status, input granted_inode, input free_count,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ifla_free_map.sv -----
// ----------------------------------------------------------------------------
// ifla_free_map
// One bit per inode; set-all sweep after reset, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ifla_free_map #(
  parameter int NUM_INODES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [$clog2(NUM_INODES)-1:0] waddr_i,
  input  logic                          wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(NUM_INODES)-1:0] raddr_i,
  output logic                          rdata_o,
  output logic                          ready_o
);
  import ifla_pkg::*;

  localparam int IW = $clog2(NUM_INODES);

  logic          mem [NUM_INODES];
  logic [IW-1:0] clr_addr_q, clr_addr_d;
  logic          init_done_q, init_done_d;
  logic          rdata_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic          mem_wdata;

  // sweep writes ones until the last entry
  always_comb begin
    clr_addr_d  = clr_addr_q;
    init_done_d = init_done_q;
    if (!init_done_q) begin
      clr_addr_d = clr_addr_q + IW'(1);
      if (clr_addr_q == IW'(NUM_INODES - 1)) begin
        init_done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      init_done_q <= 1'b0;
    end else begin
      clr_addr_q  <= clr_addr_d;
      init_done_q <= init_done_d;
    end
  end

  assign mem_we    = !init_done_q || we_i;
  assign mem_waddr = init_done_q ? waddr_i : clr_addr_q;
  assign mem_wdata = init_done_q ? wdata_i : 1'b1;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = init_done_q;

endmodule

`default_nettype wire

// ----- rtl/core/ifla_refill.sv -----
// ----------------------------------------------------------------------------
// ifla_refill
// Circular free map scan with gather buffer and reversed copy into the cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ifla_refill #(
  parameter int NUM_INODES = 1024,
  parameter int CACHE_SIZE = 16
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   start_i,
  input  logic [$clog2(NUM_INODES)-1:0]                          start_pos_i,
  input  logic                                                   map_rdata_i,
  output logic                                                   map_re_o,
  output logic [$clog2(NUM_INODES)-1:0]                          map_raddr_o,
  output logic                                                   cache_we_o,
  output logic [((CACHE_SIZE > 1) ? $clog2(CACHE_SIZE) : 1)-1:0] cache_waddr_o,
  output logic [$clog2(NUM_INODES)-1:0]                          cache_wdata_o,
  output logic                                                   done_o,
  output logic [$clog2(CACHE_SIZE + 1)-1:0]                      found_o
);
  import ifla_pkg::*;

  localparam int IW = $clog2(NUM_INODES);
  localparam int KW = $clog2(NUM_INODES + 1);
  localparam int FW = $clog2(CACHE_SIZE + 1);
  localparam int XW = (CACHE_SIZE > 1) ? $clog2(CACHE_SIZE) : 1;

  refill_state_e state_q, state_d;

  logic [IW-1:0] pos_q, pos_d, pos_nxt;
  logic [KW-1:0] iss_q, iss_d;
  logic          chk_vld_q, chk_vld_d;
  logic [IW-1:0] chk_pos_q, chk_pos_d;
  logic [FW-1:0] found_q, found_d, found_nx;
  logic [FW-1:0] cp_rd_q, cp_rd_d;
  logic          cp_pend_q, cp_pend_d;
  logic [FW-1:0] cp_idx_q, cp_idx_d;
  logic [FW-1:0] cp_waddr;

  logic [IW-1:0] gmem [CACHE_SIZE];
  logic [IW-1:0] g_rdata_q;
  logic          g_we, g_re;

  logic hit, all_issued, scan_stop, issue, copy_last;

  // position stepper, wraps at the last inode
  assign pos_nxt = (pos_q == IW'(NUM_INODES - 1)) ? '0 : pos_q + IW'(1);

  assign hit        = chk_vld_q && map_rdata_i;
  assign found_nx   = found_q + FW'(hit);
  assign all_issued = (iss_q == KW'(NUM_INODES));
  assign scan_stop  = (found_nx == FW'(CACHE_SIZE)) || (all_issued && !chk_vld_q);
  assign issue      = (state_q == RF_SCAN) && !scan_stop && !all_issued;
  assign copy_last  = (cp_rd_q == found_q) && cp_pend_q;
  assign cp_waddr   = found_q - FW'(1) - cp_idx_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      RF_IDLE: begin
        if (start_i) state_d = RF_SCAN;
      end
      RF_SCAN: begin
        if (scan_stop) state_d = (found_nx == '0) ? RF_IDLE : RF_COPY;
      end
      RF_COPY: begin
        if (copy_last) state_d = RF_IDLE;
      end
      default: state_d = RF_IDLE;
    endcase
  end

  always_comb begin
    pos_d     = pos_q;
    iss_d     = iss_q;
    chk_vld_d = 1'b0;
    chk_pos_d = chk_pos_q;
    found_d   = found_q;
    cp_rd_d   = cp_rd_q;
    cp_pend_d = 1'b0;
    cp_idx_d  = cp_idx_q;
    g_we      = 1'b0;
    g_re      = 1'b0;
    done_o    = 1'b0;
    unique case (state_q)
      RF_IDLE: begin
        if (start_i) begin
          pos_d   = start_pos_i;
          iss_d   = '0;
          found_d = '0;
        end
      end
      RF_SCAN: begin
        g_we    = hit;
        found_d = found_nx;
        if (issue) begin
          pos_d     = pos_nxt;
          iss_d     = iss_q + KW'(1);
          chk_vld_d = 1'b1;
          chk_pos_d = pos_q;
        end
        if (scan_stop) begin
          cp_rd_d = '0;
          done_o  = (found_nx == '0);
        end
      end
      RF_COPY: begin
        if (cp_rd_q != found_q) begin
          g_re      = 1'b1;
          cp_rd_d   = cp_rd_q + FW'(1);
          cp_pend_d = 1'b1;
          cp_idx_d  = cp_rd_q;
        end
        done_o = copy_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= RF_IDLE;
      chk_vld_q <= 1'b0;
      cp_pend_q <= 1'b0;
      iss_q     <= '0;
      found_q   <= '0;
      cp_rd_q   <= '0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= chk_vld_d;
      cp_pend_q <= cp_pend_d;
      iss_q     <= iss_d;
      found_q   <= found_d;
      cp_rd_q   <= cp_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    chk_pos_q <= chk_pos_d;
    cp_idx_q  <= cp_idx_d;
  end

  // gather buffer: filled in scan order, read back in the copy phase
  always_ff @(posedge clk_i) begin
    if (g_we) begin
      gmem[found_q[XW-1:0]] <= chk_pos_q;
    end
    if (g_re) begin
      g_rdata_q <= gmem[cp_rd_q[XW-1:0]];
    end
  end

  assign map_re_o      = issue;
  assign map_raddr_o   = pos_q;
  assign cache_we_o    = (state_q == RF_COPY) && cp_pend_q;
  assign cache_waddr_o = cp_waddr[XW-1:0];
  assign cache_wdata_o = g_rdata_q;
  assign found_o       = found_q;

endmodule

`default_nettype wire

// ----- rtl/core/inode_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// inode_free_list_allocator_top
// Inode allocator: free number cache in front of a one-bit-per-inode map.
// ----------------------------------------------------------------------------
// Steps: a free is answered from C_EXEC; an allocate from the cache reads the
// top slot in C_EXEC and is answered from C_POP; the response is registered.
// An allocate on an empty cache adds a scan of up to NUM_INODES map reads (one
// map read per cycle), a copy of the found numbers into the cache and one more
// pass through C_EXEC. One request at a time: ready only in C_IDLE.
// Reset: async, active low; then a sweep sets the map to all free, and the
// request channel is not ready until it finishes.
`timescale 1ns / 1ps
`default_nettype none

module inode_free_list_allocator_top #(
  parameter int NUM_INODES = 1024,
  parameter int CACHE_SIZE = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  ifla_req_if.sink   req_i,
  ifla_rsp_if.source rsp_o
);
  import ifla_pkg::*;

  localparam int IW = $clog2(NUM_INODES);
  localparam int KW = $clog2(NUM_INODES + 1);
  localparam int FW = $clog2(CACHE_SIZE + 1);
  localparam int XW = (CACHE_SIZE > 1) ? $clog2(CACHE_SIZE) : 1;

  ctrl_state_e state_q, state_d;

  // latched request
  logic             func_q;
  logic [NUM_W-1:0] num_q;
  logic [IW-1:0]    num_iw;
  logic             refilled_q;

  // allocator state
  logic [FW-1:0] fill_q, fill_dec;
  logic [IW-1:0] slot0_q;
  logic [KW-1:0] cnt_q;

  // response register
  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [NUM_W-1:0]  out_granted_q;
  logic [CNT_W-1:0]  out_count_q;
  logic              out_free;

  // cache memory
  logic [IW-1:0] cache_mem [CACHE_SIZE];
  logic [IW-1:0] cache_rdata_q;
  logic          cache_re;
  logic          cache_we;
  logic [XW-1:0] cache_waddr;
  logic [IW-1:0] cache_wdata;

  // free map and refill sequencer
  logic          map_we, map_wdata, map_re, map_rdata, map_ready;
  logic [IW-1:0] map_waddr, map_raddr;
  logic          rf_start, rf_done, rf_we;
  logic [XW-1:0] rf_waddr;
  logic [IW-1:0] rf_wdata;
  logic [FW-1:0] rf_found;
  logic [IW-1:0] rf_start_pos;

  // per-cycle decisions
  logic          accept;
  logic          res_ld;
  status_e       res_status;
  logic [IW-1:0] res_granted;
  logic          push, replace, pop;
  logic          cnt_inc, cnt_dec;
  logic          in_range, cache_full;

  assign accept     = req_i.valid && req_i.ready;
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign num_iw     = IW'(num_q);
  assign in_range   = 32'(num_q) < NUM_INODES;
  assign cache_full = 32'(fill_q) >= CACHE_SIZE;
  assign fill_dec   = fill_q - FW'(1);

  // scan starts at slot 0, or at inode 0 if slot 0 is out of range
  assign rf_start_pos = (32'(slot0_q) >= NUM_INODES) ? '0 : slot0_q;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_INIT: begin
        if (map_ready) state_d = C_IDLE;
      end
      C_IDLE: begin
        if (accept) state_d = C_EXEC;
      end
      C_EXEC: begin
        if (func_q == FUNC_FREE) begin
          if (out_free) state_d = C_IDLE;
        end else if (cnt_q == '0 || (fill_q == '0 && refilled_q)) begin
          if (out_free) state_d = C_IDLE;
        end else if (fill_q == '0) begin
          state_d = C_REFILL;
        end else begin
          state_d = C_POP;
        end
      end
      C_REFILL: begin
        if (rf_done) state_d = C_EXEC;
      end
      C_POP: begin
        if (out_free) state_d = C_IDLE;
      end
      default: state_d = C_INIT;
    endcase
  end

  // ------------------------------------------------------------------ outputs
  always_comb begin
    res_ld      = 1'b0;
    res_status  = ST_OK;
    res_granted = '0;
    push        = 1'b0;
    replace     = 1'b0;
    pop         = 1'b0;
    cnt_inc     = 1'b0;
    cnt_dec     = 1'b0;
    cache_re    = 1'b0;
    rf_start    = 1'b0;
    map_we      = 1'b0;
    map_waddr   = num_iw;
    map_wdata   = 1'b1;
    unique case (state_q)
      C_EXEC: begin
        if (func_q == FUNC_FREE) begin
          if (out_free) begin
            res_ld = 1'b1;
            if (!in_range) begin
              res_status = ST_RANGE;
            end else begin
              push    = !cache_full;
              replace = cache_full && (32'(slot0_q) > 32'(num_q));
              map_we  = 1'b1;
              cnt_inc = cnt_q < KW'(NUM_INODES);  // saturates on double free
            end
          end
        end else if (cnt_q == '0 || (fill_q == '0 && refilled_q)) begin
          res_ld     = out_free;
          res_status = ST_NONE;
        end else if (fill_q == '0) begin
          rf_start = 1'b1;
        end else begin
          cache_re = 1'b1;  // top of cache, data in C_POP
        end
      end
      C_POP: begin
        if (out_free) begin
          res_ld      = 1'b1;
          res_granted = cache_rdata_q;
          pop         = 1'b1;
          cnt_dec     = 1'b1;
          map_we      = 1'b1;
          map_waddr   = cache_rdata_q;
          map_wdata   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign req_i.ready = (state_q == C_IDLE);

  // --------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_INIT;
      fill_q      <= '0;
      slot0_q     <= '0;
      cnt_q       <= KW'(NUM_INODES);
      refilled_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        refilled_q <= 1'b0;
      end else if (state_q == C_REFILL && rf_done) begin
        refilled_q <= 1'b1;
      end
      if (state_q == C_REFILL && rf_done) begin
        fill_q <= rf_found;
      end else if (push) begin
        fill_q <= fill_q + FW'(1);
      end else if (pop) begin
        fill_q <= fill_dec;
      end
      if (cache_we && cache_waddr == '0) begin
        slot0_q <= cache_wdata;
      end
      if (cnt_inc) begin
        cnt_q <= cnt_q + KW'(1);
      end else if (cnt_dec) begin
        cnt_q <= cnt_q - KW'(1);
      end
      if (res_ld) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_i.func;
      num_q  <= req_i.inode_number;
    end
    if (res_ld) begin
      out_status_q  <= res_status;
      out_granted_q <= NUM_W'(res_granted);
      // counter value after this operation
      if (cnt_inc) begin
        out_count_q <= CNT_W'(cnt_q + KW'(1));
      end else if (cnt_dec) begin
        out_count_q <= CNT_W'(cnt_q - KW'(1));
      end else begin
        out_count_q <= CNT_W'(cnt_q);
      end
    end
  end

  // cache write port: refill copy, push at fill, or slot 0 replace
  always_comb begin
    cache_we    = rf_we || push || replace;
    cache_waddr = '0;
    cache_wdata = num_iw;
    if (rf_we) begin
      cache_waddr = rf_waddr;
      cache_wdata = rf_wdata;
    end else if (push) begin
      cache_waddr = fill_q[XW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cache_we) begin
      cache_mem[cache_waddr] <= cache_wdata;
    end
    if (cache_re) begin
      cache_rdata_q <= cache_mem[fill_dec[XW-1:0]];
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.granted_inode = out_granted_q;
  assign rsp_o.free_count    = out_count_q;

  // ----------------------------------------------------------- submodules
  ifla_free_map #(
    .NUM_INODES (NUM_INODES)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata),
    .ready_o (map_ready)
  );

  ifla_refill #(
    .NUM_INODES (NUM_INODES),
    .CACHE_SIZE (CACHE_SIZE)
  ) u_refill (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (rf_start),
    .start_pos_i   (rf_start_pos),
    .map_rdata_i   (map_rdata),
    .map_re_o      (map_re),
    .map_raddr_o   (map_raddr),
    .cache_we_o    (rf_we),
    .cache_waddr_o (rf_waddr),
    .cache_wdata_o (rf_wdata),
    .done_o        (rf_done),
    .found_o       (rf_found)
  );

endmodule

`default_nettype wire

// ----- rtl/core/ifla_checker.sv -----
// ----------------------------------------------------------------------------
// ifla_checker
// Port-level checks on the inode allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "inode_free_list_allocator_top_assert.svh"

module ifla_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  rsp_status_i,
  input logic [9:0]  rsp_granted_i,
  input logic [10:0] rsp_count_i
);
  import ifla_pkg::*;

  // stalled response holds
  `IFLA_ASSERT_NXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable({rsp_status_i, rsp_granted_i, rsp_count_i}), "response changed while stalled")

  // failed operations hand out no inode number
  `IFLA_ASSERT_IMP(a_fail_no_grant, rsp_valid_i && rsp_status_i != ST_OK, rsp_granted_i == '0, "granted inode set on failed operation")

  // no undefined status code
  `IFLA_ASSERT_IMP(a_status_code, rsp_valid_i, rsp_status_i == ST_OK || rsp_status_i == ST_NONE || rsp_status_i == ST_RANGE, "bad status code")

  // one operation at a time: not ready right after a transfer
  `IFLA_ASSERT_NXT(a_busy_after_req, req_valid_i && req_ready_i, !req_ready_i, "request ready while busy")

endmodule

bind inode_free_list_allocator_top ifla_checker u_ifla_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_granted_i (rsp_o.granted_inode),
  .rsp_count_i   (rsp_o.free_count)
);

`default_nettype wire
